// ===== rtl/prs80_pkg.sv =====
`timescale 1ns / 1ps

package prs80_pkg;

  localparam int MAX_ROUNDS_DEF = 31;
  localparam int BLOCK_W        = 64;
  localparam int KEY_W          = 80;
  localparam int KEY_HIGH_W     = 16;
  localparam int COUNT_W        = 5;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [COUNT_W-1:0] count_t;

  function automatic logic [3:0] sbox(input logic [3:0] x);
    logic [3:0] y;
    unique case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

  function automatic block_t sub_layer(input block_t s);
    block_t r;
    for (int n = 0; n < 16; n++) begin
      r[4*n +: 4] = sbox(s[4*n +: 4]);
    end
    return r;
  endfunction

  // Bit i moves to 16*i mod 63; the top bit stays where it is.
  function automatic block_t perm_layer(input block_t s);
    block_t r;
    for (int i = 0; i < 63; i++) begin
      r[(16 * i) % 63] = s[i];
    end
    r[63] = s[63];
    return r;
  endfunction

endpackage

// ===== rtl/prs80_round.sv =====
`timescale 1ns / 1ps

module prs80_round #(
  parameter int ROUND_IDX = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  prs80_pkg::block_t in_state,
  input  prs80_pkg::key_t   in_key,
  input  prs80_pkg::count_t rounds,
  output logic            out_valid,
  output prs80_pkg::block_t out_state,
  output prs80_pkg::key_t   out_key
);

  localparam prs80_pkg::count_t RoundNum = prs80_pkg::COUNT_W'(ROUND_IDX);

  prs80_pkg::block_t state_next;
  prs80_pkg::key_t   key_rot;
  prs80_pkg::key_t   key_next;
  logic              active;

  // Stages beyond the configured count pass the item through untouched.
  assign active = (RoundNum <= rounds);

  always_comb begin
    key_rot          = {in_key[18:0], in_key[79:19]};
    key_rot[79:76]   = prs80_pkg::sbox(key_rot[79:76]);
    key_rot[19:15]   = key_rot[19:15] ^ RoundNum;
    if (active) begin
      state_next = prs80_pkg::perm_layer(prs80_pkg::sub_layer(in_state ^ in_key[79:16]));
      key_next   = key_rot;
    end else begin
      state_next = in_state;
      key_next   = in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_state <= state_next;
    out_key   <= key_next;
  end

endmodule

// ===== rtl/present80_block_encrypt_unit.sv =====
`timescale 1ns / 1ps

// PRESENT-80 encryption engine, fully unrolled: one register stage per round
// plus an output register, so a new item may be started in every cycle and
// its ciphertext appears after the round stages and the output register,
// marked by done for one cycle. Every item passes through all round stages
// whatever round_count holds; stages past the configured count pass the item
// through. busy never rises and done cannot be held off, so the receiver must
// take every result in the cycle it is shown. round_count of zero acts as one;
// a count at or above MAX_ROUNDS runs the full cipher with the final key
// addition. round_count is to be written only while no item is in flight.
module present80_block_encrypt_unit #(
  parameter int MAX_ROUNDS = prs80_pkg::MAX_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] plaintext,
  input  logic [63:0] key_low,
  input  logic [15:0] key_high,
  input  logic        round_count_valid,
  output logic        round_count_ready,
  input  logic [4:0]  round_count,
  output logic        done,
  output logic [63:0] ciphertext
);

  localparam prs80_pkg::count_t MaxCount = prs80_pkg::COUNT_W'(MAX_ROUNDS);

  prs80_pkg::count_t rounds;
  prs80_pkg::count_t rounds_next;

  logic              stage_valid [0:MAX_ROUNDS];
  prs80_pkg::block_t stage_state [0:MAX_ROUNDS];
  prs80_pkg::key_t   stage_key   [0:MAX_ROUNDS];

  assign busy              = 1'b0;
  assign round_count_ready = 1'b1;

  // The count is held already saturated, so the stages compare directly.
  always_comb begin
    if (round_count == '0) begin
      rounds_next = prs80_pkg::COUNT_W'(1);
    end else if (round_count > MaxCount) begin
      rounds_next = MaxCount;
    end else begin
      rounds_next = round_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rounds <= MaxCount;
    end else if (round_count_valid && round_count_ready) begin
      rounds <= rounds_next;
    end
  end

  assign stage_valid[0] = start;
  assign stage_state[0] = plaintext;
  assign stage_key[0]   = {key_high, key_low};

  for (genvar g = 1; g <= MAX_ROUNDS; g++) begin : g_round
    prs80_round #(
      .ROUND_IDX(g)
    ) u_round (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stage_valid[g-1]),
      .in_state (stage_state[g-1]),
      .in_key   (stage_key[g-1]),
      .rounds   (rounds),
      .out_valid(stage_valid[g]),
      .out_state(stage_state[g]),
      .out_key  (stage_key[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid[MAX_ROUNDS];
    end
  end

  // Only the full cipher ends with the last round key added.
  always_ff @(posedge clk) begin
    if (rounds == MaxCount) begin
      ciphertext <= stage_state[MAX_ROUNDS] ^ stage_key[MAX_ROUNDS][79:16];
    end else begin
      ciphertext <= stage_state[MAX_ROUNDS];
    end
  end

endmodule
